/* sv/vector4_normalizer_macros.svh */
// ----------------------------------------------------------------------------
// vector4_normalizer_macros
// assertion macros for the vector normalizer checker
// ----------------------------------------------------------------------------
`ifndef VECTOR4_NORMALIZER_MACROS_SVH
`define VECTOR4_NORMALIZER_MACROS_SVH
// assert that an implication holds on every clock edge outside reset
`define V4N_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assert that a property holds on every clock edge, reset included
`define V4N_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* sv/v4n_pkg.sv */
// ----------------------------------------------------------------------------
// v4n_pkg
// types and constants shared by the vector normalizer modules
// ----------------------------------------------------------------------------
package v4n_pkg;
   localparam int IN_WIDTH      = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int THR_WIDTH     = 16;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;

   typedef struct packed {
      logic signed [15:0] comp_x;
      logic signed [15:0] comp_y;
      logic signed [15:0] comp_z;
      logic signed [15:0] comp_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] unit_x;
      logic signed [15:0] unit_y;
      logic signed [15:0] unit_z;
      logic signed [15:0] unit_w;
      logic        [16:0] length;
      logic               near_zero;
   } rsp_type;
endpackage

/* sv/v4n_sqrt.sv */
// ----------------------------------------------------------------------------
// v4n_sqrt
// pipelined floored square root, one result bit per stage
// ----------------------------------------------------------------------------
module v4n_sqrt #(
   parameter int SUM_WIDTH = 34,
   parameter int ROOT_WIDTH = 17,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [SUM_WIDTH-1:0]  in_sum,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_root,
   output logic [SIDE_WIDTH-1:0] out_side
);
   localparam int RW = 2 * ROOT_WIDTH + 2;

   logic [ROOT_WIDTH:0]  valid_ff;
   logic [RW-1:0]        rem_ff  [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH+1];
   logic [SIDE_WIDTH-1:0] side_ff [ROOT_WIDTH+1];

   // stage 0 holds the operand; stage k has decided the top k root bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_WIDTH-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= RW'(in_sum);
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      localparam int B = ROOT_WIDTH - 1 - k;
      logic [RW-1:0] trial_in;
      logic [ROOT_WIDTH-1:0] cand_in;
      always_comb begin
         cand_in = root_ff[k] | (ROOT_WIDTH'(1) << B);
         trial_in = RW'(cand_in) * RW'(cand_in);
      end
      // compare candidate square against the full sum
      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[k+1] <= side_ff[k];
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= (trial_in <= rem_ff[k]) ? cand_in : root_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH];
   assign out_root  = root_ff[ROOT_WIDTH];
   assign out_side  = side_ff[ROOT_WIDTH];
endmodule

/* sv/v4n_div_lane.sv */
// ----------------------------------------------------------------------------
// v4n_div_lane
// pipelined restoring divider for one component, one quotient bit per stage
// ----------------------------------------------------------------------------
module v4n_div_lane #(
   parameter int NUM_WIDTH = 31,
   parameter int DEN_WIDTH = 17
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [NUM_WIDTH-1:0] in_num,
   input  logic [DEN_WIDTH-1:0] in_den,
   output logic [NUM_WIDTH-1:0] out_quo
);
   localparam int PW = DEN_WIDTH + 1;

   logic [PW-1:0]        rem_ff [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
      end
   end

   // num_ff shifts left: dividend bits out the top, quotient bits in the bottom
   for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_stage
      logic [PW:0] shift_in;
      logic [PW:0] diff_in;
      always_comb begin
         shift_in = {rem_ff[k], num_ff[k][NUM_WIDTH-1]};
         diff_in  = shift_in - (PW+1)'(den_ff[k]);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k+1] <= den_ff[k];
            if (!diff_in[PW]) begin
               rem_ff[k+1] <= diff_in[PW-1:0];
               num_ff[k+1] <= {num_ff[k][NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= shift_in[PW-1:0];
               num_ff[k+1] <= {num_ff[k][NUM_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   assign out_quo = num_ff[NUM_WIDTH];
endmodule

/* sv/vector4_normalizer.sv */
// ----------------------------------------------------------------------------
// vector4_normalizer
// scales a four-component Q8.8 vector to unit length in Q1.14, with magnitude
// ----------------------------------------------------------------------------
//  channel  ports      direction  contents
//  request  req_*      in         comp_x..comp_w, signed Q8.8
//  result   rsp_*      out        unit_x..unit_w Q1.14, length Q9.8, near_zero
//  config   csr_*      in         near_zero_threshold, Q8.8
//
// one item per cycle; an item passes 1 + 1 + (IN_WIDTH+2) + (IN_WIDTH+OUT_FRAC_BITS+2)
// + 1 register stages, set by the bit-per-stage root and the four divider lanes
// reset clears all valid bits and loads the threshold with one
// the whole pipeline advances whenever the output register is empty or taken;
// a stall on rsp holds every stage, and req_stall follows from that
module vector4_normalizer #(
   parameter int IN_WIDTH      = v4n_pkg::IN_WIDTH,
   parameter int OUT_FRAC_BITS = v4n_pkg::OUT_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  v4n_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output v4n_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [v4n_pkg::THR_WIDTH-1:0]        csr_data
);
   localparam int MW  = IN_WIDTH + 1;          // component magnitude
   localparam int SW  = 2 * MW + 2;            // sum of four squares
   localparam int LW  = IN_WIDTH + 1;          // root / length
   localparam int NW  = MW + OUT_FRAC_BITS;    // dividend
   localparam int UW  = OUT_FRAC_BITS + 2;     // unit field
   localparam int SIDE = 4 * (MW + 1);         // magnitudes and signs alongside

   logic advance;
   logic [v4n_pkg::THR_WIDTH-1:0] thr_ff;

   // stage 1: magnitudes and signs
   logic          s1_valid_ff;
   logic [MW-1:0] s1_mag_ff [4];
   logic [3:0]    s1_neg_ff;
   // stage 2: squares summed
   logic          s2_valid_ff;
   logic [SW-1:0] s2_sum_ff;
   logic [SIDE-1:0] s2_side_ff;

   logic [IN_WIDTH-1:0] comp_in [4];
   logic          root_valid;
   logic [LW-1:0] root_len;
   logic [SIDE-1:0] root_side;

   logic [NW:0]   div_valid_ff;
   logic [LW-1:0] len_ff [NW+1];
   logic [3:0]    neg_ff [NW+1];
   logic [NW-1:0] quo [4];

   logic    rsp_valid_ff;
   v4n_pkg::rsp_type rsp_ff, rsp_in;
   logic [UW-1:0] unit_in [4];
   logic          nz_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= v4n_pkg::THR_RESET;
      end else if (csr_write) begin
         thr_ff <= csr_data;
      end
   end

   assign comp_in[0] = IN_WIDTH'(req_data.comp_x);
   assign comp_in[1] = IN_WIDTH'(req_data.comp_y);
   assign comp_in[2] = IN_WIDTH'(req_data.comp_z);
   assign comp_in[3] = IN_WIDTH'(req_data.comp_w);

   // lanes: absolute value of each component
   for (genvar i = 0; i < 4; i++) begin : g_abs
      always_ff @(posedge clock) begin
         if (advance) begin
            s1_neg_ff[i] <= comp_in[i][IN_WIDTH-1];
            s1_mag_ff[i] <= comp_in[i][IN_WIDTH-1] ? MW'(-$signed({1'b1, comp_in[i]}))
                                                   : MW'(comp_in[i]);
         end
      end
   end

   // merge: sum of squares
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff <= SW'(s1_mag_ff[0] * s1_mag_ff[0]) + SW'(s1_mag_ff[1] * s1_mag_ff[1])
                    + SW'(s1_mag_ff[2] * s1_mag_ff[2]) + SW'(s1_mag_ff[3] * s1_mag_ff[3]);
         s2_side_ff <= {s1_neg_ff, s1_mag_ff[0], s1_mag_ff[1], s1_mag_ff[2], s1_mag_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   v4n_sqrt #(.SUM_WIDTH(SW), .ROOT_WIDTH(LW), .SIDE_WIDTH(SIDE)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s2_valid_ff), .in_sum(s2_sum_ff), .in_side(s2_side_ff),
      .out_valid(root_valid), .out_root(root_len), .out_side(root_side)
   );

   // divider lanes, one per component
   for (genvar i = 0; i < 4; i++) begin : g_div
      logic [MW-1:0] mag_in;
      assign mag_in = root_side[(3-i)*MW +: MW];
      v4n_div_lane #(.NUM_WIDTH(NW), .DEN_WIDTH(LW)) u_div (
         .clock(clock), .advance(advance),
         .in_num({mag_in, {OUT_FRAC_BITS{1'b0}}}),
         .in_den(root_len), .out_quo(quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         len_ff[0] <= root_len;
         neg_ff[0] <= root_side[SIDE-1 -: 4];
         for (int k = 0; k < NW; k++) begin
            len_ff[k+1] <= len_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
      end else if (advance) begin
         div_valid_ff <= {div_valid_ff[NW-1:0], root_valid};
      end
   end

   // merge: sign, saturation, near-zero decision
   // sign bit i belongs to component i
   always_comb begin
      logic [NW-1:0] q;
      nz_in = (len_ff[NW] <= LW'(thr_ff)) || (len_ff[NW] == '0);
      for (int i = 0; i < 4; i++) begin
         q = (quo[i] > NW'(1 << OUT_FRAC_BITS)) ? NW'(1 << OUT_FRAC_BITS) : quo[i];
         unit_in[i] = nz_in ? '0 : (neg_ff[NW][i] ? UW'(-q) : UW'(q));
      end
      rsp_in.unit_x    = 16'(signed'(unit_in[0]));
      rsp_in.unit_y    = 16'(signed'(unit_in[1]));
      rsp_in.unit_z    = 16'(signed'(unit_in[2]));
      rsp_in.unit_w    = 16'(signed'(unit_in[3]));
      rsp_in.length    = 17'(len_ff[NW]);
      rsp_in.near_zero = nz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

/* sv/v4n_checker.sv */
// ----------------------------------------------------------------------------
// v4n_checker
// port-level checks for the vector normalizer, bound to the top level
// ----------------------------------------------------------------------------
`include "vector4_normalizer_macros.svh"
module v4n_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input v4n_pkg::rsp_type rsp_data
);
   `V4N_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result item changed while stalled")
   `V4N_ASSERT(a_stall_follow, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output backpressure")
   `V4N_ASSERT(a_nz_units, clock, reset, rsp_valid && rsp_data.near_zero |-> rsp_data.unit_x == 16'sd0 && rsp_data.unit_y == 16'sd0 && rsp_data.unit_z == 16'sd0 && rsp_data.unit_w == 16'sd0, "near-zero item has nonzero components")
   `V4N_ASSERT(a_zero_len, clock, reset, rsp_valid && rsp_data.length == 17'd0 |-> rsp_data.near_zero, "zero length without near-zero flag")
   `V4N_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")
endmodule

bind vector4_normalizer v4n_checker u_v4n_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
